// File: rtl/rmm_pkg.sv
// Shared constants, types and state codes for the range min/max tree block.
`timescale 1ns / 1ps
package rmm_pkg;
  localparam int LEAVES = 1024;
  localparam int LVL_W  = $clog2(LEAVES);
  localparam int ADDR_W = LVL_W + 1;
  localparam int HEAP_W = LVL_W + 2;
  localparam int DEPTH  = 2 * LEAVES;
  localparam int VAL_W  = 31;

  localparam logic signed [VAL_W-1:0] IDENT_MIN = 31'sd1073741823;
  localparam logic signed [VAL_W-1:0] IDENT_MAX = -31'sd1073741823;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     is_query;
    logic                     q_empty;
    logic [ADDR_W-1:0]        pos;
    logic signed [VAL_W-1:0]  value;
    logic [HEAP_W-1:0]        l;
    logic [HEAP_W-1:0]        r;
  } rmm_cmd_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_WUP,
    ST_QL,
    ST_QR,
    ST_QFIN
  } rmm_state_t;
endpackage

// File: rtl/rmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/rmm_front.sv
// Input side: decode, clamp and saturate requests, then queue them.
`timescale 1ns / 1ps
module rmm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              clr_busy,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rmm_pkg::rmm_cmd_t cmd
);
  import rmm_pkg::*;

  logic [9:0]              leaf_index;
  logic signed [VAL_W-1:0] leaf_value;
  logic [10:0]             range_start;
  logic [10:0]             range_end;
  logic [10:0]             s_sat;
  logic [10:0]             e_sat;
  logic                    drop;
  logic                    push;
  logic                    pop;
  rmm_cmd_t                cmd_in;
  rmm_cmd_t                slot [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;

  assign leaf_index  = s_axis_tdata[9:0];
  assign leaf_value  = s_axis_tdata[40:10];
  assign range_start = s_axis_tdata[51:41];
  assign range_end   = s_axis_tdata[62:52];

  assign s_sat = (range_start > 11'(LEAVES)) ? 11'(LEAVES) : range_start;
  assign e_sat = (range_end > 11'(LEAVES)) ? 11'(LEAVES) : range_end;

  always_comb begin
    cmd_in.is_query = (s_axis_tuser == MODE_QUERY);
    cmd_in.q_empty  = (s_sat >= e_sat);
    cmd_in.pos      = ADDR_W'(leaf_index) + ADDR_W'(LEAVES);
    // the one code below the range is the most negative value
    cmd_in.value    = (leaf_value < IDENT_MAX) ? IDENT_MAX : leaf_value;
    cmd_in.l        = HEAP_W'(s_sat) + HEAP_W'(LEAVES);
    cmd_in.r        = HEAP_W'(e_sat) + HEAP_W'(LEAVES);
  end

  // drop writes beyond the last leaf; a 10-bit leaf index never goes beyond it
  assign drop = (s_axis_tuser == MODE_WRITE) && ({1'b0, leaf_index} >= 11'(LEAVES));

  assign s_axis_tready = (count != 2'd2) && !clr_busy;
  assign push          = s_axis_tvalid && s_axis_tready && !drop;
  assign cmd_valid     = (count != 2'd0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/rmm_back.sv
// Execution side: tree memories, path update, range walk and result register.
`timescale 1ns / 1ps
module rmm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rmm_pkg::rmm_cmd_t cmd,
  output logic              clr_busy,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,
  output logic              m_axis_tuser
);
  import rmm_pkg::*;

  rmm_state_t              state, state_next;
  logic [ADDR_W-1:0]       clr_cnt, clr_cnt_next;
  logic [ADDR_W-1:0]       pos, pos_next;
  logic signed [VAL_W-1:0] cur_min, cur_min_next;
  logic signed [VAL_W-1:0] cur_max, cur_max_next;
  logic [HEAP_W-1:0]       l, l_next;
  logic [HEAP_W-1:0]       r, r_next;
  logic signed [VAL_W-1:0] acc_min, acc_min_next;
  logic signed [VAL_W-1:0] acc_max, acc_max_next;
  logic                    rd_pend, rd_pend_next;
  logic                    q_empty, q_empty_next;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_min, out_max;
  logic                    out_empty;
  logic                    out_load;

  logic                    we;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [VAL_W-1:0]        wmin, wmax;
  logic [VAL_W-1:0]        rmin, rmax;
  logic signed [VAL_W-1:0] rd_min, rd_max;
  logic signed [VAL_W-1:0] up_min, up_max;
  logic [ADDR_W-1:0]       par;
  logic [HEAP_W-1:0]       l_dec, r_dec;

  rmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_min_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wmin), .raddr(raddr), .rdata(rmin)
  );
  rmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_max_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wmax), .raddr(raddr), .rdata(rmax)
  );

  assign rd_min = $signed(rmin);
  assign rd_max = $signed(rmax);
  assign par    = pos >> 1;
  assign up_min = (rd_min < cur_min) ? rd_min : cur_min;
  assign up_max = (rd_max > cur_max) ? rd_max : cur_max;

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    pos_next     = pos;
    cur_min_next = cur_min;
    cur_max_next = cur_max;
    l_next       = l;
    r_next       = r;
    l_dec        = l;
    r_dec        = r;
    q_empty_next = q_empty;
    rd_pend_next = 1'b0;
    acc_min_next = acc_min;
    acc_max_next = acc_max;
    we           = 1'b0;
    waddr        = pos;
    wmin         = cur_min;
    wmax         = cur_max;
    raddr        = pos ^ ADDR_W'(1);
    cmd_ready    = 1'b0;
    out_load     = 1'b0;

    if (rd_pend) begin
      if (rd_min < acc_min) acc_min_next = rd_min;
      if (rd_max > acc_max) acc_max_next = rd_max;
    end

    unique case (state)
      ST_CLR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        wmin         = IDENT_MIN;
        wmax         = IDENT_MAX;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == {ADDR_W{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.is_query) begin
            acc_min_next = IDENT_MIN;
            acc_max_next = IDENT_MAX;
            q_empty_next = cmd.q_empty;
            l_next       = cmd.l;
            r_next       = cmd.r;
            state_next   = cmd.q_empty ? ST_QFIN : ST_QL;
          end else begin
            // store the leaf and fetch its sibling
            we           = 1'b1;
            waddr        = cmd.pos;
            wmin         = cmd.value;
            wmax         = cmd.value;
            raddr        = cmd.pos ^ ADDR_W'(1);
            pos_next     = cmd.pos;
            cur_min_next = cmd.value;
            cur_max_next = cmd.value;
            state_next   = ST_WUP;
          end
        end
      end
      ST_WUP: begin
        // combine with sibling, write parent, fetch parent's sibling
        we           = 1'b1;
        waddr        = par;
        wmin         = up_min;
        wmax         = up_max;
        raddr        = par ^ ADDR_W'(1);
        cur_min_next = up_min;
        cur_max_next = up_max;
        pos_next     = par;
        if (par == ADDR_W'(1)) state_next = ST_IDLE;
      end
      ST_QL: begin
        if (l < r) begin
          if (l[0]) begin
            raddr        = l[ADDR_W-1:0];
            rd_pend_next = 1'b1;
            l_next       = l + HEAP_W'(1);
          end
          state_next = ST_QR;
        end else begin
          state_next = ST_QFIN;
        end
      end
      ST_QR: begin
        if (r[0]) begin
          r_dec        = r - HEAP_W'(1);
          raddr        = r_dec[ADDR_W-1:0];
          rd_pend_next = 1'b1;
        end
        l_next     = l_dec >> 1;
        r_next     = r_dec >> 1;
        state_next = ST_QL;
      end
      ST_QFIN: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      rd_pend <= rd_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    cur_min <= cur_min_next;
    cur_max <= cur_max_next;
    l       <= l_next;
    r       <= r_next;
    acc_min <= acc_min_next;
    acc_max <= acc_max_next;
    q_empty <= q_empty_next;
    if (out_load) begin
      out_min   <= acc_min;
      out_max   <= acc_max;
      out_empty <= q_empty;
    end
  end

  assign clr_busy      = (state == ST_CLR);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_max, out_min};
  assign m_axis_tuser  = out_empty;
endmodule

// File: rtl/range_min_max_segment_tree_top.sv
// Top level of the range minimum/maximum segment tree.
// Reset (synchronous) runs a clearing pass over all 2048 tree entries that loads the
// identity values; input is held off until it ends.
// A write updates one tree level per cycle, from the leaf up to the root.
// A query walks one level per ST_QL/ST_QR pair until the bounds meet, then ST_QFIN.
// One request runs at a time; a two-entry queue and the result register decouple the sides.
`timescale 1ns / 1ps
module range_min_max_segment_tree_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] leaf_index, [40:10] leaf_value, [51:41] range_start,
  // [62:52] range_end, [63] zero
  input  logic [63:0] s_axis_tdata,
  // [0] mode: 0 writes a leaf, 1 queries a range
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [30:0] range_min, [61:31] range_max, [63:62] zero
  output logic [63:0] m_axis_tdata,
  // [0] range_empty
  output logic        m_axis_tuser
);
  import rmm_pkg::*;

  rmm_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_ready;
  logic     clr_busy;

  // Front: decode the request, clamp the value, saturate the bounds,
  // drop writes past the last leaf, queue the rest.
  rmm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clr_busy      (clr_busy),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // Back: clear and update the trees, walk them for queries and hold the result until taken.
  rmm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .clr_busy      (clr_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );
endmodule
